// ===== design/rmh_pkg.sv =====
package rmh_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MED_W    = 33;
  localparam int CNT_W    = 11;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_PUSH,
    OP_REPLACE
  } heap_op_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_UP,
    H_DOWN,
    H_FIN
  } heap_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_CLASS,
    C_WAIT,
    C_OUT
  } ctl_state_t;

  typedef struct packed {
    logic                       first_sample;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    heap_op_t                   op;
    logic signed [SAMPLE_W-1:0] val;
  } heap_cmd_t;

  typedef struct packed {
    logic                       busy;
    logic signed [SAMPLE_W-1:0] top;
  } heap_stat_t;

endpackage

// ===== design/rmh_in_if.sv =====
interface rmh_in_if;
  logic                                valid;
  logic                                ready;
  logic                                first_sample;
  logic signed [rmh_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, first_sample, sample, input ready);
  modport sink (input valid, first_sample, sample, output ready);
endinterface

// ===== design/rmh_out_if.sv =====
interface rmh_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmh_pkg::MED_W-1:0]   median_twice;
  logic        [rmh_pkg::CNT_W-1:0]   sample_count;
  logic                               overflow;

  modport source (output valid, median_twice, sample_count, overflow, input ready);
  modport sink (input valid, median_twice, sample_count, overflow, output ready);
endinterface

// ===== design/rmh_ram.sv =====
module rmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/rmh_front.sv =====
module rmh_front (
  input  logic           clk,
  input  logic           rst,
  rmh_in_if.sink         in_ch,
  output logic           q_valid,
  output rmh_pkg::item_t q_item,
  input  logic           q_pop
);

  rmh_pkg::item_t slot [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;
  logic           push;
  logic           pop;

  assign in_ch.ready = (cnt != 2'd2);
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (cnt != 2'd0);
  assign pop         = q_pop & q_valid;
  assign q_item      = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= '{first_sample: in_ch.first_sample, sample: in_ch.sample};
    end
  end

endmodule

// ===== design/rmh_heap.sv =====
module rmh_heap #(
  parameter int   DEPTH  = 512,
  parameter logic IS_MAX = 1'b1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rmh_pkg::heap_cmd_t           cmd,
  output rmh_pkg::heap_stat_t          stat,
  output logic [$clog2(DEPTH+1)-1:0]   size
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int EW = AW + 2;

  rmh_pkg::heap_state_t state, state_next;
  logic [AW-1:0]                       idx, idx_next;
  logic signed [rmh_pkg::SAMPLE_W-1:0] val, val_next;
  logic [SW-1:0]                       size_next;
  logic signed [rmh_pkg::SAMPLE_W-1:0] top;

  logic                                we;
  logic [AW-1:0]                       waddr;
  logic signed [rmh_pkg::SAMPLE_W-1:0] wdata;
  logic [AW-1:0]                       ra;
  logic [AW-1:0]                       rb;
  logic signed [rmh_pkg::SAMPLE_W-1:0] rd_a;
  logic signed [rmh_pkg::SAMPLE_W-1:0] rd_b;

  logic [AW-1:0]                       par;
  logic [EW-1:0]                       c_a;
  logic [EW-1:0]                       c_b;
  logic                                pick_b;
  logic signed [rmh_pkg::SAMPLE_W-1:0] hc;
  logic [AW-1:0]                       cidx;
  logic [EW-1:0]                       nc_a;
  logic [EW-1:0]                       nc_b;

  function automatic logic ahead(logic signed [rmh_pkg::SAMPLE_W-1:0] a,
                                 logic signed [rmh_pkg::SAMPLE_W-1:0] b);
    return IS_MAX ? (a > b) : (a < b);
  endfunction

  function automatic logic [AW-1:0] parent(logic [AW-1:0] x);
    return (x - AW'(1)) >> 1;
  endfunction

  rmh_ram #(
    .WIDTH (rmh_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign par    = parent(idx);
  assign c_a    = {1'b0, idx, 1'b1};
  assign c_b    = c_a + 1'b1;
  assign pick_b = (c_b < EW'(size)) && ahead(rd_b, rd_a);
  assign hc     = pick_b ? rd_b : rd_a;
  assign cidx   = pick_b ? c_b[AW-1:0] : c_a[AW-1:0];
  assign nc_a   = {1'b0, cidx, 1'b1};
  assign nc_b   = nc_a + 1'b1;

  assign stat.busy = (state != rmh_pkg::H_IDLE);
  assign stat.top  = top;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmh_pkg::H_IDLE;
      size  <= '0;
    end else begin
      state <= state_next;
      size  <= size_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    val <= val_next;
    if (we && waddr == '0) begin
      top <= wdata;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    val_next   = val;
    size_next  = size;
    we         = 1'b0;
    waddr      = idx;
    wdata      = val;
    ra         = '0;
    rb         = '0;
    case (state)
      rmh_pkg::H_IDLE: begin
        val_next = cmd.val;
        case (cmd.op)
          rmh_pkg::OP_CLEAR: begin
            size_next = '0;
          end
          rmh_pkg::OP_PUSH: begin
            size_next = size + 1'b1;
            if (size == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = cmd.val;
            end else begin
              idx_next   = AW'(size);
              ra         = parent(AW'(size));
              state_next = rmh_pkg::H_UP;
            end
          end
          rmh_pkg::OP_REPLACE: begin
            idx_next = '0;
            if (size <= SW'(1)) begin
              we    = 1'b1;
              waddr = '0;
              wdata = cmd.val;
            end else begin
              ra         = AW'(1);
              rb         = AW'(2);
              state_next = rmh_pkg::H_DOWN;
            end
          end
          default: ;
        endcase
      end
      rmh_pkg::H_UP: begin
        we = 1'b1;
        if (ahead(val, rd_a)) begin
          wdata    = rd_a;
          idx_next = par;
          if (par == '0) begin
            state_next = rmh_pkg::H_FIN;
          end else begin
            ra = parent(par);
          end
        end else begin
          state_next = rmh_pkg::H_IDLE;
        end
      end
      rmh_pkg::H_DOWN: begin
        we = 1'b1;
        if (ahead(hc, val)) begin
          wdata    = hc;
          idx_next = cidx;
          if (nc_a >= EW'(size)) begin
            state_next = rmh_pkg::H_FIN;
          end else begin
            ra = nc_a[AW-1:0];
            rb = nc_b[AW-1:0];
          end
        end else begin
          state_next = rmh_pkg::H_IDLE;
        end
      end
      rmh_pkg::H_FIN: begin
        we         = 1'b1;
        state_next = rmh_pkg::H_IDLE;
      end
      default: begin
        state_next = rmh_pkg::H_IDLE;
      end
    endcase
  end

endmodule

// ===== design/running_median_two_heaps_core.sv =====
// Running median over a stream of signed 32-bit samples.
// in_ch carries first_sample and sample; out_ch carries median_twice (twice
// the median, one fractional bit), sample_count and overflow. Both are
// valid/ready channels; a transaction happens when valid and ready are high.
// Every input transaction gives exactly one output transaction, in order.
// A two-entry input queue takes transactions while the back end works.
// The back end keeps a max-heap and a min-heap, each in its own RAM with
// a cached top, and runs the sift on both heaps at once, one tree level
// per cycle. An item that overflows skips the heaps and goes from the
// classify step straight to the output; any other item waits until
// both heaps have finished their sift before its result is loaded.
// The result sits in an output register; while the receiver stalls the
// back end finishes the next item and then waits, and the queue fills.
// Reset empties both heaps and the queue; no clearing pass is needed.
// first_sample empties the heaps before its sample goes in. When both
// heaps hold HEAP_DEPTH samples, a sample is dropped and overflow is set.
module running_median_two_heaps_core #(
  parameter int HEAP_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst,
  rmh_in_if.sink     in_ch,
  rmh_out_if.source  out_ch
);

  localparam int SW = $clog2(HEAP_DEPTH + 1);
  localparam logic [SW:0] FULL = (SW + 1)'(2 * HEAP_DEPTH);

  logic                                q_valid;
  rmh_pkg::item_t                      q_item;
  logic                                q_pop;

  rmh_pkg::ctl_state_t                 state, state_next;
  logic signed [rmh_pkg::SAMPLE_W-1:0] cur, cur_next;
  logic                                ovf, ovf_next;

  rmh_pkg::heap_cmd_t                  lcmd, ucmd;
  rmh_pkg::heap_stat_t                 lstat, ustat;
  logic [SW-1:0]                       lsz, usz;

  logic [SW:0]                         tot;
  logic signed [rmh_pkg::MED_W-1:0]    m2;
  logic signed [rmh_pkg::MED_W-1:0]    x2;
  logic signed [rmh_pkg::MED_W-1:0]    med;
  logic                                load;

  logic                                out_valid;
  logic signed [rmh_pkg::MED_W-1:0]    out_med;
  logic [rmh_pkg::CNT_W-1:0]           out_cnt;
  logic                                out_ovf;

  rmh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rmh_heap #(
    .DEPTH  (HEAP_DEPTH),
    .IS_MAX (1'b1)
  ) u_lower (
    .clk  (clk),
    .rst  (rst),
    .cmd  (lcmd),
    .stat (lstat),
    .size (lsz)
  );

  rmh_heap #(
    .DEPTH  (HEAP_DEPTH),
    .IS_MAX (1'b0)
  ) u_upper (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ucmd),
    .stat (ustat),
    .size (usz)
  );

  assign tot = {1'b0, lsz} + {1'b0, usz};
  assign m2  = $signed({lstat.top[rmh_pkg::SAMPLE_W-1], lstat.top})
             + $signed({ustat.top[rmh_pkg::SAMPLE_W-1], ustat.top});
  assign x2  = {cur, 1'b0};

  always_comb begin
    if (lsz > usz) begin
      med = {lstat.top, 1'b0};
    end else if (usz > lsz) begin
      med = {ustat.top, 1'b0};
    end else if (lsz != '0) begin
      med = m2;
    end else begin
      med = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmh_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    ovf <= ovf_next;
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    ovf_next   = ovf;
    q_pop      = 1'b0;
    load       = 1'b0;
    lcmd       = '{op: rmh_pkg::OP_NOP, val: cur};
    ucmd       = '{op: rmh_pkg::OP_NOP, val: cur};
    case (state)
      rmh_pkg::C_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_item.sample;
          state_next = rmh_pkg::C_CLASS;
          if (q_item.first_sample) begin
            lcmd.op = rmh_pkg::OP_CLEAR;
            ucmd.op = rmh_pkg::OP_CLEAR;
          end
        end
      end
      rmh_pkg::C_CLASS: begin
        ovf_next   = 1'b0;
        state_next = rmh_pkg::C_WAIT;
        if (tot >= FULL) begin
          ovf_next   = 1'b1;
          state_next = rmh_pkg::C_OUT;
        end else if (lsz == '0 && usz == '0) begin
          lcmd.op = rmh_pkg::OP_PUSH;
        end else if (lsz > usz) begin
          if (cur > lstat.top) begin
            ucmd.op = rmh_pkg::OP_PUSH;
          end else begin
            ucmd    = '{op: rmh_pkg::OP_PUSH, val: lstat.top};
            lcmd.op = rmh_pkg::OP_REPLACE;
          end
        end else if (usz > lsz) begin
          if (cur < ustat.top) begin
            lcmd.op = rmh_pkg::OP_PUSH;
          end else begin
            lcmd    = '{op: rmh_pkg::OP_PUSH, val: ustat.top};
            ucmd.op = rmh_pkg::OP_REPLACE;
          end
        end else if (x2 > m2) begin
          ucmd.op = rmh_pkg::OP_PUSH;
        end else begin
          lcmd.op = rmh_pkg::OP_PUSH;
        end
      end
      rmh_pkg::C_WAIT: begin
        if (!lstat.busy && !ustat.busy) begin
          state_next = rmh_pkg::C_OUT;
        end
      end
      rmh_pkg::C_OUT: begin
        if (!out_valid || out_ch.ready) begin
          load       = 1'b1;
          state_next = rmh_pkg::C_IDLE;
        end
      end
      default: begin
        state_next = rmh_pkg::C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_med <= med;
      out_cnt <= rmh_pkg::CNT_W'(tot);
      out_ovf <= ovf;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.median_twice = out_med;
  assign out_ch.sample_count = out_cnt;
  assign out_ch.overflow     = out_ovf;

  a_balanced: assert property (@(posedge clk) disable iff (rst)
    (state == rmh_pkg::C_IDLE) |->
      (lsz == usz || lsz == usz + 1'b1 || usz == lsz + 1'b1))
    else $error("heap sizes out of balance");

  a_heaps_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == rmh_pkg::C_IDLE || state == rmh_pkg::C_OUT) |->
      (!lstat.busy && !ustat.busy))
    else $error("heap busy outside of a sift");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (load && ovf) |-> (tot == FULL))
    else $error("overflow with room left");

endmodule
